// ----- rtl/wsd_pkg.sv -----
// Shared types, constants and tables for the waypoint steering decision unit.
`default_nettype none
package wsd_pkg;

  localparam int HEAD_W     = 13;
  localparam int OBS_W      = 10;
  localparam int DUTY_W     = 16;
  localparam int ERR_W      = 13;
  localparam int RANGE_W    = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int MAX_CORDIC = 24;
  localparam int Z_W        = 23;
  localparam int SCALE_SH   = 16;
  localparam int FULL_TURN  = 5760;
  localparam int HALF_TURN  = 2880;
  localparam int STRAIGHT_BAND = 80;
  localparam int RECIP5     = 52429;   // ceil(2^18 / 5)
  localparam int RECIP5_SH  = 18;

  localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(737280);  // 180 deg in 1/4096 deg

  typedef enum logic [MODE_W-1:0] {
    MODE_STOP     = 2'd0,
    MODE_TURN     = 2'd1,
    MODE_STRAIGHT = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARRIVE = 3'd0,
    REG_TOL    = 3'd1,
    REG_OBS    = 3'd2,
    REG_MAX    = 3'd3,
    REG_MIN    = 3'd4,
    REG_LGAIN  = 3'd5,
    REG_RGAIN  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] arrive;
    logic [11:0] tol;
    logic [9:0]  obs;
    logic [15:0] max_duty;
    logic [15:0] min_duty;
    logic [15:0] lgain;
    logic [15:0] rgain;
  } cfg_t;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic              ob_valid;
    logic [OBS_W-1:0]  ob_dist;
  } meta_t;

  // atan(2^-i) in 1/4096 degree
  function automatic logic signed [Z_W-1:0] atan_lut(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(184320);
      1:  v = Z_W'(108810);
      2:  v = Z_W'(57492);
      3:  v = Z_W'(29184);
      4:  v = Z_W'(14649);
      5:  v = Z_W'(7331);
      6:  v = Z_W'(3667);
      7:  v = Z_W'(1833);
      8:  v = Z_W'(917);
      9:  v = Z_W'(458);
      10: v = Z_W'(229);
      11: v = Z_W'(115);
      12: v = Z_W'(57);
      13: v = Z_W'(29);
      14: v = Z_W'(14);
      15: v = Z_W'(7);
      16: v = Z_W'(4);
      17: v = Z_W'(2);
      18: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/wsd_front.sv -----
// Front stages: goal offsets, squared range and CORDIC start vector.
`default_nettype none
module wsd_front #(
  parameter int CB  = 16,
  parameter int CW  = CB + 20,
  parameter int SQW = 2 * CB + 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      rdy_o,
  input  wire logic [CB-1:0]        pos_x_i,
  input  wire logic [CB-1:0]        pos_z_i,
  input  wire logic [CB-1:0]        goal_x_i,
  input  wire logic [CB-1:0]        goal_z_i,
  input  wire wsd_pkg::meta_t       meta_i,
  output logic                      valid_o,
  input  wire logic                 rdy_i,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output logic signed [wsd_pkg::Z_W-1:0] z_o,
  output logic [SQW-1:0]            n_o,
  output logic                      zero_o,
  output wsd_pkg::meta_t            meta_o
);
  import wsd_pkg::*;

  logic a_v_q, b_v_q, en_a, en_b;
  logic signed [CB:0] dx_q, dz_q;
  meta_t a_meta_q;

  logic signed [CB:0] dx_d, dz_d;
  logic [CB:0] ax, az;
  logic [SQW-1:0] sx, sz;
  logic signed [CW-1:0] dxs, dzs, x_d, y_d;
  logic signed [Z_W-1:0] z_d;

  assign en_b  = ~b_v_q | rdy_i;
  assign en_a  = ~a_v_q | en_b;
  assign rdy_o = en_a;

  assign dx_d = $signed({goal_x_i[CB-1], goal_x_i}) - $signed({pos_x_i[CB-1], pos_x_i});
  assign dz_d = $signed({goal_z_i[CB-1], goal_z_i}) - $signed({pos_z_i[CB-1], pos_z_i});

  always_comb begin
    ax  = dx_q[CB] ? (~dx_q + 1'b1) : dx_q;
    az  = dz_q[CB] ? (~dz_q + 1'b1) : dz_q;
    sx  = ax * ax;
    sz  = az * az;
    dxs = CW'(dx_q) <<< SCALE_SH;
    dzs = CW'(dz_q) <<< SCALE_SH;
    if (dz_q > 0) begin
      x_d = dzs;
      y_d = dxs;
      z_d = (dx_q <= 0) ? Z_HALF : -Z_HALF;
    end else begin
      x_d = -dzs;
      y_d = -dxs;
      z_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q <= valid_i;
      if (en_b) b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      dx_q     <= dx_d;
      dz_q     <= dz_d;
      a_meta_q <= meta_i;
    end
    if (en_b) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      n_o    <= sx + sz;
      zero_o <= (dx_q == '0) && (dz_q == '0);
      meta_o <= a_meta_q;
    end
  end

  assign valid_o = b_v_q;

endmodule
`default_nettype wire

// ----- rtl/wsd_core.sv -----
// Stage array: up to one CORDIC vectoring step and one square root digit per stage.
`default_nettype none
module wsd_core #(
  parameter int CB    = 16,
  parameter int STEPS = 16,
  parameter int CW    = CB + 20,
  parameter int SQW   = 2 * CB + 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      rdy_o,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [wsd_pkg::Z_W-1:0] z_i,
  input  wire logic [SQW-1:0]       n_i,
  input  wire logic                 zero_i,
  input  wire wsd_pkg::meta_t       meta_i,
  output logic                      valid_o,
  input  wire logic                 rdy_i,
  output logic signed [wsd_pkg::Z_W-1:0] z_o,
  output logic [CB:0]               dist_o,
  output logic                      zero_o,
  output wsd_pkg::meta_t            meta_o
);
  import wsd_pkg::*;

  localparam int CSE = (STEPS > MAX_CORDIC) ? MAX_CORDIC : STEPS;
  localparam int K   = SQW / 2;
  localparam int NS  = (CSE > K) ? CSE : K;

  logic                  v_q    [NS];
  logic signed [CW-1:0]  x_q    [NS];
  logic signed [CW-1:0]  y_q    [NS];
  logic signed [Z_W-1:0] z_q    [NS];
  logic [SQW-1:0]        n_q    [NS];
  logic [SQW-1:0]        r_q    [NS];
  logic                  zero_q [NS];
  meta_t                 meta_q [NS];
  logic [NS:0]           en;

  assign en[NS] = rdy_i;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                  v_in, zero_in;
    logic signed [CW-1:0]  x_in, y_in, x_d, y_d;
    logic signed [Z_W-1:0] z_in, z_d;
    logic [SQW-1:0]        n_in, r_in, n_d, r_d;
    meta_t                 meta_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign x_in    = x_i;
      assign y_in    = y_i;
      assign z_in    = z_i;
      assign n_in    = n_i;
      assign r_in    = '0;
      assign zero_in = zero_i;
      assign meta_in = meta_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign x_in    = x_q[k-1];
      assign y_in    = y_q[k-1];
      assign z_in    = z_q[k-1];
      assign n_in    = n_q[k-1];
      assign r_in    = r_q[k-1];
      assign zero_in = zero_q[k-1];
      assign meta_in = meta_q[k-1];
    end

    if (k < CSE) begin : g_rot
      always_comb begin
        if (y_in > 0) begin
          x_d = x_in + (y_in >>> k);
          y_d = y_in - (x_in >>> k);
          z_d = z_in + atan_lut(k);
        end else begin
          x_d = x_in - (y_in >>> k);
          y_d = y_in + (x_in >>> k);
          z_d = z_in - atan_lut(k);
        end
      end
    end else begin : g_rot_idle
      assign x_d = x_in;
      assign y_d = y_in;
      assign z_d = z_in;
    end

    if (k < K) begin : g_root
      localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
      logic [SQW:0] trial;
      always_comb begin
        trial = {1'b0, r_in} + {1'b0, BIT};
        if ({1'b0, n_in} >= trial) begin
          n_d = n_in - trial[SQW-1:0];
          r_d = (r_in >> 1) + BIT;
        end else begin
          n_d = n_in;
          r_d = r_in >> 1;
        end
      end
    end else begin : g_root_idle
      assign n_d = n_in;
      assign r_d = r_in;
    end

    assign en[k] = ~v_q[k] | en[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        x_q[k]    <= x_d;
        y_q[k]    <= y_d;
        z_q[k]    <= z_d;
        n_q[k]    <= n_d;
        r_q[k]    <= r_d;
        zero_q[k] <= zero_in;
        meta_q[k] <= meta_in;
      end
    end
  end

  assign rdy_o   = en[0];
  assign valid_o = v_q[NS-1];
  assign z_o     = z_q[NS-1];
  assign dist_o  = r_q[NS-1][CB:0];
  assign zero_o  = zero_q[NS-1];
  assign meta_o  = meta_q[NS-1];

endmodule
`default_nettype wire

// ----- rtl/wsd_drive.sv -----
// Back stages: bearing, heading error, mode choice and calibrated wheel duties.
`default_nettype none
module wsd_drive #(
  parameter int CB = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire wsd_pkg::cfg_t        cfg_i,
  input  wire logic                 valid_i,
  output logic                      rdy_o,
  input  wire logic signed [wsd_pkg::Z_W-1:0] z_i,
  input  wire logic [CB:0]          dist_i,
  input  wire logic                 zero_i,
  input  wire wsd_pkg::meta_t       meta_i,
  output logic                      valid_o,
  input  wire logic                 rdy_i,
  output wsd_pkg::mode_e            mode_o,
  output logic [wsd_pkg::DUTY_W-1:0]  left_o,
  output logic [wsd_pkg::DUTY_W-1:0]  right_o,
  output logic [wsd_pkg::ERR_W-1:0]   err_o,
  output logic [wsd_pkg::RANGE_W-1:0] range_o
);
  import wsd_pkg::*;

  localparam int BW = Z_W - 8;
  localparam int EW = 15;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  // stage 1
  logic signed [Z_W-1:0] zs;
  logic signed [BW-1:0]  zr, bw;
  logic [HEAD_W-1:0]     b1_q, h1_q;
  logic                  near1_q, arr1_q;
  logic [RANGE_W-1:0]    rng1_q;
  // stage 2
  logic signed [EW-1:0]  e_raw, e_w, e_abs;
  logic [33:0]           base_p;
  mode_e                 mode_d, mode2_q, mode3_q, mode4_q, mode5_q;
  logic [ERR_W-1:0]      err2_q, err3_q, err4_q, err5_q;
  logic [RANGE_W-1:0]    rng2_q, rng3_q, rng4_q, rng5_q;
  logic                  band2_q, pos2_q;
  logic [15:0]           base2_q;
  // stage 3
  logic [19:0]           s9;
  logic [36:0]           slow_p;
  logic [15:0]           slow, ls3_q, rs3_q;
  // stage 4
  logic [31:0]           lp4, rp4;
  logic [16:0]           l4_q, r4_q;
  // stage 5
  logic [16:0]           lm, rm;
  logic [32:0]           lp5, rp5;
  logic [17:0]           l5_q, r5_q;

  assign en6   = ~v6_q | rdy_i;
  assign en5   = ~v5_q | en6;
  assign en4   = ~v4_q | en5;
  assign en3   = ~v3_q | en4;
  assign en2   = ~v2_q | en3;
  assign en1   = ~v1_q | en2;
  assign rdy_o = en1;

  always_comb begin
    zs = z_i + Z_W'(128);
    zr = BW'(zs >>> 8);
    if (zr < 0) begin
      bw = zr + BW'(FULL_TURN);
    end else if (zr >= BW'(FULL_TURN)) begin
      bw = zr - BW'(FULL_TURN);
    end else begin
      bw = zr;
    end
  end

  always_comb begin
    e_raw = $signed({2'b00, b1_q}) - $signed({2'b00, h1_q});
    if (e_raw > EW'(HALF_TURN)) begin
      e_w = e_raw - EW'(FULL_TURN);
    end else if (e_raw < -EW'(HALF_TURN)) begin
      e_w = e_raw + EW'(FULL_TURN);
    end else begin
      e_w = e_raw;
    end
    e_abs = (e_w < 0) ? -e_w : e_w;
    if (near1_q || arr1_q) begin
      mode_d = MODE_STOP;
    end else if (e_abs > $signed({3'b000, cfg_i.tol})) begin
      mode_d = MODE_TURN;
    end else begin
      mode_d = MODE_STRAIGHT;
    end
    base_p = {cfg_i.max_duty, 2'b00} * 16'(RECIP5);
  end

  always_comb begin
    s9     = base2_q * 4'd9;
    slow_p = s9[19:1] * 18'(RECIP5);
    slow   = slow_p[RECIP5_SH +: 16];
  end

  assign lp4 = ls3_q * cfg_i.lgain;
  assign rp4 = rs3_q * cfg_i.rgain;

  always_comb begin
    lm  = (l4_q < {1'b0, cfg_i.min_duty}) ? {1'b0, cfg_i.min_duty} : l4_q;
    rm  = (r4_q < {1'b0, cfg_i.min_duty}) ? {1'b0, cfg_i.min_duty} : r4_q;
    lp5 = lm * cfg_i.lgain;
    rp5 = rm * cfg_i.rgain;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      b1_q    <= zero_i ? '0 : HEAD_W'(bw);
      h1_q    <= meta_i.head;
      near1_q <= meta_i.ob_valid && (meta_i.ob_dist < cfg_i.obs);
      arr1_q  <= 32'(dist_i) < 32'(cfg_i.arrive);
      rng1_q  <= (dist_i > (CB + 1)'(16'hFFFF)) ? 16'hFFFF : RANGE_W'(dist_i);
    end
    if (en2) begin
      mode2_q <= mode_d;
      err2_q  <= ERR_W'(e_w);
      rng2_q  <= rng1_q;
      band2_q <= e_abs > EW'(STRAIGHT_BAND);
      pos2_q  <= e_w > 0;
      base2_q <= base_p[RECIP5_SH +: 16];
    end
    if (en3) begin
      mode3_q <= mode2_q;
      err3_q  <= err2_q;
      rng3_q  <= rng2_q;
      ls3_q   <= (band2_q && pos2_q) ? slow : base2_q;
      rs3_q   <= (band2_q && !pos2_q) ? slow : base2_q;
    end
    if (en4) begin
      mode4_q <= mode3_q;
      err4_q  <= err3_q;
      rng4_q  <= rng3_q;
      l4_q    <= lp4[31:15];
      r4_q    <= rp4[31:15];
    end
    if (en5) begin
      mode5_q <= mode4_q;
      err5_q  <= err4_q;
      rng5_q  <= rng4_q;
      l5_q    <= lp5[32:15];
      r5_q    <= rp5[32:15];
    end
    if (en6) begin
      mode_o  <= mode5_q;
      err_o   <= err5_q;
      range_o <= rng5_q;
      if (mode5_q == MODE_STRAIGHT) begin
        left_o  <= (l5_q > 18'h0FFFF) ? 16'hFFFF : l5_q[15:0];
        right_o <= (r5_q > 18'h0FFFF) ? 16'hFFFF : r5_q[15:0];
      end else begin
        left_o  <= '0;
        right_o <= '0;
      end
    end
  end

  assign valid_o = v6_q;

endmodule
`default_nettype wire

// ----- rtl/waypoint_steering_decision_unit.sv -----
// Top level of the waypoint steering decision unit: config registers and pipeline.
//
// Input beats on s_axis carry position, heading, goal and an obstacle reading;
// s_axis_tuser_i carries the obstacle valid flag. Output beats on m_axis carry
// wheel duties, heading error and range; m_axis_tuser_o carries the mode
// (stop, turn, drive straight). One output beat per input beat, in order.
// Throughput is one beat per cycle unless m_axis_tready_i holds the pipeline back.
// Every stage holds its own valid bit and moves when the next stage is free, so
// a stalled receiver fills the empty stages first; s_axis_tready_o drops only
// when the whole pipeline holds beats. Reset empties the pipeline and loads the
// register defaults. Registers are written through cfg_we_i, cfg_addr_i and
// cfg_wdata_i, by the user only while no beats are in flight; no logic enforces it.
`default_nettype none
module waypoint_steering_decision_unit #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [wsd_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [wsd_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // pos_x, pos_z, heading, goal_x, goal_z, obstacle_dist, zero pad
  input  wire logic [((4*COORD_BITS+23+7)/8)*8-1:0] s_axis_tdata_i,
  // obstacle_valid
  input  wire logic [0:0]                s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // left_duty, right_duty, heading_error, range_to_goal, zero pad
  output logic [63:0]                    m_axis_tdata_o,
  // mode
  output logic [1:0]                     m_axis_tuser_o
);
  import wsd_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int CW  = CB + 20;
  localparam int SQW = 2 * CB + 2;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arrive   <= 16'd100;
      cfg_q.tol      <= 12'd80;
      cfg_q.obs      <= 10'd200;
      cfg_q.max_duty <= 16'd8191;
      cfg_q.min_duty <= 16'd0;
      cfg_q.lgain    <= 16'd32768;
      cfg_q.rgain    <= 16'd32768;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ARRIVE: cfg_q.arrive   <= cfg_wdata_i;
        REG_TOL:    cfg_q.tol      <= cfg_wdata_i[11:0];
        REG_OBS:    cfg_q.obs      <= cfg_wdata_i[9:0];
        REG_MAX:    cfg_q.max_duty <= cfg_wdata_i;
        REG_MIN:    cfg_q.min_duty <= cfg_wdata_i;
        REG_LGAIN:  cfg_q.lgain    <= cfg_wdata_i;
        REG_RGAIN:  cfg_q.rgain    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [CB-1:0] pos_x, pos_z, goal_x, goal_z;
  meta_t in_meta;

  assign pos_x            = s_axis_tdata_i[0 +: CB];
  assign pos_z            = s_axis_tdata_i[CB +: CB];
  assign in_meta.head     = s_axis_tdata_i[2*CB +: HEAD_W];
  assign goal_x           = s_axis_tdata_i[2*CB+HEAD_W +: CB];
  assign goal_z           = s_axis_tdata_i[3*CB+HEAD_W +: CB];
  assign in_meta.ob_dist  = s_axis_tdata_i[4*CB+HEAD_W +: OBS_W];
  assign in_meta.ob_valid = s_axis_tuser_i[0];

  logic                  f_v, f_rdy;
  logic signed [CW-1:0]  f_x, f_y;
  logic signed [Z_W-1:0] f_z;
  logic [SQW-1:0]        f_n;
  logic                  f_zero;
  meta_t                 f_meta;

  wsd_front #(.CB(CB), .CW(CW), .SQW(SQW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .rdy_o   (s_axis_tready_o),
    .pos_x_i (pos_x),
    .pos_z_i (pos_z),
    .goal_x_i(goal_x),
    .goal_z_i(goal_z),
    .meta_i  (in_meta),
    .valid_o (f_v),
    .rdy_i   (f_rdy),
    .x_o     (f_x),
    .y_o     (f_y),
    .z_o     (f_z),
    .n_o     (f_n),
    .zero_o  (f_zero),
    .meta_o  (f_meta)
  );

  logic                  c_v, c_rdy;
  logic signed [Z_W-1:0] c_z;
  logic [CB:0]           c_dist;
  logic                  c_zero;
  meta_t                 c_meta;

  wsd_core #(.CB(CB), .STEPS(CORDIC_STEPS), .CW(CW), .SQW(SQW)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_v),
    .rdy_o   (f_rdy),
    .x_i     (f_x),
    .y_i     (f_y),
    .z_i     (f_z),
    .n_i     (f_n),
    .zero_i  (f_zero),
    .meta_i  (f_meta),
    .valid_o (c_v),
    .rdy_i   (c_rdy),
    .z_o     (c_z),
    .dist_o  (c_dist),
    .zero_o  (c_zero),
    .meta_o  (c_meta)
  );

  mode_e                o_mode;
  logic [DUTY_W-1:0]    o_left, o_right;
  logic [ERR_W-1:0]     o_err;
  logic [RANGE_W-1:0]   o_range;

  wsd_drive #(.CB(CB)) u_drive (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (c_v),
    .rdy_o   (c_rdy),
    .z_i     (c_z),
    .dist_i  (c_dist),
    .zero_i  (c_zero),
    .meta_i  (c_meta),
    .valid_o (m_axis_tvalid_o),
    .rdy_i   (m_axis_tready_i),
    .mode_o  (o_mode),
    .left_o  (o_left),
    .right_o (o_right),
    .err_o   (o_err),
    .range_o (o_range)
  );

  assign m_axis_tdata_o = {3'b000, o_range, o_err, o_right, o_left};
  assign m_axis_tuser_o = o_mode;

endmodule
`default_nettype wire
